[design/set_assoc_cache_tags_lru_macros.svh]
// Assertion shorthands shared by the RTL.
`ifndef SET_ASSOC_CACHE_TAGS_LRU_MACROS_SVH
`define SET_ASSOC_CACHE_TAGS_LRU_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SACTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SACTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sactl_pkg.sv]
`timescale 1ns / 1ps

package sactl_pkg;

  localparam int OFFSET_BITS_DEF = 2;
  localparam int INDEX_BITS_DEF  = 4;
  localparam int WAYS_DEF        = 4;
  localparam int AGE_BITS_DEF    = 16;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int REGION_HI = 31;
  localparam int REGION_LO = 24;
  localparam int REGION_W  = REGION_HI - REGION_LO + 1;
  localparam int WAY_OUT_W = 2;

  localparam logic [REGION_W-1:0] UNCACHED_RESET = 8'h0f;

  localparam logic OP_FETCH = 1'b0;
  localparam logic OP_INVAL = 1'b1;

endpackage

[design/set_assoc_cache_tags_lru.sv]
`timescale 1ns / 1ps
// Set-associative tag store with per-line age counters for LRU replacement.
// Command side: a word (in_opcode, in_address) is taken on a clock edge with
// start high and busy low. Opcode fetch looks up / fills, opcode invalidate
// drops a matching line.
// Result side: one word per command, shown on the out_ ports for exactly one
// cycle while out_valid is high. The receiver cannot stall; nothing waits.
// Config: cfg_we with cfg_wdata writes the uncached-region top byte; write
// it only while the block is idle.
// The accepting edge reads the set's tag and age rows from the synchronous
// RAMs; in ST_LOOK the block compares, ages, picks the victim and, on a
// cached fetch, writes the row back, and the result word is registered at
// the end of ST_LOOK. busy covers ST_LOOK, so no new command is taken until
// the row is written; the next read always sees it and no forwarding is needed.
// Reset (rst_n low, synchronous): valid bits of all lines cleared at once,
// hit and fetch counters zeroed, uncached byte back to 0x0f. Tag and age
// RAM contents are left as they are; they are only read behind a valid bit.

module set_assoc_cache_tags_lru #(
  parameter int OFFSET_BITS = sactl_pkg::OFFSET_BITS_DEF,
  parameter int INDEX_BITS  = sactl_pkg::INDEX_BITS_DEF,
  parameter int WAYS        = sactl_pkg::WAYS_DEF,
  parameter int AGE_BITS    = sactl_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [sactl_pkg::ADDR_W-1:0]        in_address,
  // result channel
  output logic                                out_valid,
  output logic                                out_hit,
  output logic                                out_uncached,
  output logic [sactl_pkg::WAY_OUT_W-1:0]     out_way_used,
  output logic                                out_evicted,
  output logic [sactl_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sactl_pkg::CNT_W-1:0]         out_fetch_total,
  // config register
  input  logic                                cfg_we,
  input  logic [sactl_pkg::REGION_W-1:0]      cfg_wdata
);

`include "set_assoc_cache_tags_lru_macros.svh"

  localparam int SETS  = 1 << INDEX_BITS;
  localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int TAG_W = sactl_pkg::ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------
  // Command capture
  // ---------------------------------------------------------------------
  logic             accept;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;
  logic             in_bypass;

  assign busy      = (state_r == ST_LOOK);
  assign accept    = start && !busy;
  assign in_set    = SET_W'(in_address >> OFFSET_BITS) & SET_W'(SETS - 1);
  assign in_tag    = TAG_W'(in_address >> (OFFSET_BITS + INDEX_BITS));

  logic [sactl_pkg::REGION_W-1:0] uncached_r;
  assign in_bypass = (in_address[sactl_pkg::REGION_HI:sactl_pkg::REGION_LO] == uncached_r);

  logic             op_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic             bypass_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_opcode;
      set_r    <= in_set;
      tag_r    <= in_tag;
      bypass_r <= in_bypass;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uncached_r <= sactl_pkg::UNCACHED_RESET;
    end else if (cfg_we) begin
      uncached_r <= cfg_wdata;
    end
  end

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_LOOK : ST_IDLE;
      ST_LOOK: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line storage: one row per set, all ways side by side.
  // ---------------------------------------------------------------------
  logic [WAYS*TAG_W-1:0]    tag_mem [SETS];
  logic [WAYS*AGE_BITS-1:0] age_mem [SETS];
  logic [WAYS*TAG_W-1:0]    tag_rd_r;
  logic [WAYS*AGE_BITS-1:0] age_rd_r;
  logic [WAYS*TAG_W-1:0]    tag_wr;
  logic [WAYS*AGE_BITS-1:0] age_wr;
  logic                     row_we;
  logic [WAYS-1:0]          valid_r [SETS];

  always_ff @(posedge clk) begin
    if (row_we) begin
      tag_mem[set_r] <= tag_wr;
    end
    if (accept) begin
      tag_rd_r <= tag_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      age_mem[set_r] <= age_wr;
    end
    if (accept) begin
      age_rd_r <= age_mem[in_set];
    end
  end

  // ---------------------------------------------------------------------
  // Lookup / update, in ST_LOOK
  // ---------------------------------------------------------------------
  logic [WAYS-1:0]     vrow;
  logic [WAYS-1:0]     match;
  logic [AGE_BITS-1:0] aged [WAYS];
  logic                any_match;
  logic [WAY_W-1:0]    hit_way;
  logic                any_free;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    victim;
  logic [AGE_BITS-1:0] victim_age;
  logic [WAY_W-1:0]    fill_way;
  logic                is_fetch;
  logic                do_lookup;
  logic                do_fill;
  logic [WAY_W-1:0]    way_sel;
  logic [WAY_W+1:0]    way_ext;

  assign vrow = valid_r[set_r];

  always_comb begin
    logic [TAG_W-1:0]    tw;
    logic [AGE_BITS-1:0] aw;
    for (int w = 0; w < WAYS; w++) begin
      tw       = tag_rd_r[w*TAG_W +: TAG_W];
      aw       = age_rd_r[w*AGE_BITS +: AGE_BITS];
      match[w] = vrow[w] && (tw == tag_r);
      if (match[w]) begin
        aged[w] = '0;
      end else if (vrow[w] && (aw != AGE_MAX)) begin
        aged[w] = aw + 1'b1;
      end else begin
        aged[w] = aw;
      end
    end
  end

  // lowest-numbered way wins on hit and on free slot
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!vrow[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  assign any_match = |match;
  assign any_free  = ~&vrow;

  // first way holding the greatest (post-aging) age
  always_comb begin
    victim     = '0;
    victim_age = aged[0];
    for (int w = 1; w < WAYS; w++) begin
      if (aged[w] > victim_age) begin
        victim     = WAY_W'(w);
        victim_age = aged[w];
      end
    end
  end

  assign fill_way  = any_free ? free_way : victim;
  assign is_fetch  = (op_r == sactl_pkg::OP_FETCH);
  assign do_lookup = busy && is_fetch && !bypass_r;
  assign do_fill   = do_lookup && !any_match;
  assign row_we    = do_lookup;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (!any_match && (fill_way == WAY_W'(w))) begin
        age_wr[w*AGE_BITS +: AGE_BITS] = '0;
        tag_wr[w*TAG_W +: TAG_W]       = tag_r;
      end else begin
        age_wr[w*AGE_BITS +: AGE_BITS] = aged[w];
        tag_wr[w*TAG_W +: TAG_W]       = tag_rd_r[w*TAG_W +: TAG_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (do_fill) begin
      valid_r[set_r][fill_way] <= 1'b1;
    end else if (busy && !is_fetch && any_match) begin
      valid_r[set_r][hit_way] <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Counters and result word
  // ---------------------------------------------------------------------
  logic [sactl_pkg::CNT_W-1:0] hit_cnt_r;
  logic [sactl_pkg::CNT_W-1:0] fetch_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      fetch_cnt_r <= '0;
    end else if (busy && is_fetch) begin
      fetch_cnt_r <= fetch_cnt_r + 1'b1;
      if (do_lookup && any_match) begin
        hit_cnt_r <= hit_cnt_r + 1'b1;
      end
    end
  end

  // a bypassed fetch reports way 0; a fetch miss reports the filled way
  assign way_sel = (is_fetch && bypass_r) ? '0 :
                   (is_fetch && !any_match) ? fill_way : hit_way;
  assign way_ext = {2'b00, way_sel};

  logic                              out_valid_r;
  logic                              out_hit_r;
  logic                              out_uncached_r;
  logic [sactl_pkg::WAY_OUT_W-1:0]   out_way_r;
  logic                              out_evicted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_hit_r      <= any_match && !(is_fetch && bypass_r);
      out_uncached_r <= is_fetch && bypass_r;
      out_way_r      <= way_ext[sactl_pkg::WAY_OUT_W-1:0];
      out_evicted_r  <= do_fill && !any_free;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_uncached    = out_uncached_r;
  assign out_way_used    = out_way_r;
  assign out_evicted     = out_evicted_r;
  assign out_hit_total   = hit_cnt_r;
  assign out_fetch_total = fetch_cnt_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `SACTL_ASSERT_IMP(a_acc_to_result, clk, rst_n, accept, ##2 out_valid_r, "result missing two cycles after accept")
  `SACTL_ASSERT_IMP(a_result_from_look, clk, rst_n, out_valid_r, $past(state_r) == ST_LOOK, "result without lookup cycle")
  `SACTL_ASSERT_IMP(a_evict_is_miss, clk, rst_n, out_valid_r && out_evicted_r, !out_hit_r && !out_uncached_r, "eviction on hit or bypass")
  `SACTL_ASSERT_IMP(a_hit_cnt_step, clk, rst_n, $past(rst_n) && (hit_cnt_r != $past(hit_cnt_r)), out_valid_r && out_hit_r && (fetch_cnt_r != $past(fetch_cnt_r)), "hit count moved without a fetch hit")
  `SACTL_ASSERT_NXT(a_fill_sets_valid, clk, rst_n, do_fill, valid_r[$past(set_r)][$past(fill_way)], "filled line not valid")

endmodule
